// ----- rtl/core/ksel_pkg.sv -----
package ksel_pkg;

  localparam int SEED_W   = 32;
  localparam int CNT_W    = 24;
  localparam int VAL_W    = 64;
  localparam int BKT_BITS = 8;
  localparam int NBKT     = 1 << BKT_BITS;
  localparam int DEPTH    = 4096;
  localparam int DADDR_W  = $clog2(DEPTH);
  localparam int DCNT_W   = DADDR_W + 1;
  localparam int NCELL    = 16;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_RANK_ERR = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  typedef struct packed {
    logic signed [SEED_W-1:0] seed;
    logic [CNT_W-1:0]         count;
    logic [CNT_W-1:0]         rank;
  } in_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] kth_value;
    logic [1:0]              status;
  } out_t;

  // data handed from one cell to the next
  typedef struct packed {
    logic             v;
    logic [VAL_W-1:0] d;
  } link_t;

  typedef enum logic [2:0] {
    S_IDLE, S_CLEAR, S_HIST, S_SCAN, S_STORE, S_SEL, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    SS_IDLE, SS_LOAD, SS_STREAM, SS_CHECK
  } sstate_t;

  function automatic logic [VAL_W-1:0] xs_next(input logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 7);
    y = y ^ (y << 17);
    return y;
  endfunction

endpackage

// ----- rtl/core/xorshift_stream_kth_smallest.sv -----
// A zero seed or a bad rank goes from idle straight to the result; otherwise the item passes
//   through the clear, histogram, scan, store and (unless the store overflows) select phases.
// Throughput: one item at a time; busy stays high through the result strobe.
// Generator passes run one value a cycle; selection streams the store past a 16-cell row.
// Reset (rst_n low, synchronous) returns control to idle; the result cannot be stalled.
module xorshift_stream_kth_smallest import ksel_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_item,
  output logic out_valid,
  output out_t out_item
);

  state_t             state_r, state_nxt;
  logic [VAL_W-1:0]   seed_r, gen_r;
  logic [CNT_W-1:0]   count_r, cnt_r, rem_r;
  logic [BKT_BITS:0]  clr_r, so_r;
  logic               hv_r, hwv_r, sv_r, found_r;
  logic [BKT_BITS-1:0] hb_r, hwb_r, sb_r, chosen_r;
  logic [CNT_W-1:0]   hwd_r, hrd_r, hval;
  logic [CNT_W:0]     stored_r;
  out_t               res_r;

  logic [CNT_W-1:0]   hist [NBKT];
  logic               h_we;
  logic [BKT_BITS-1:0] h_wa, h_ra, gtop;
  logic [CNT_W-1:0]   h_wd;
  logic               gen_live, s_we, sel_go, sel_done;
  logic [VAL_W-1:0]   sel_val;
  logic               accept;
  logic [VAL_W-1:0]   seed_x;

  assign accept   = start && !busy;
  assign seed_x   = {{(VAL_W-SEED_W){in_item.seed[SEED_W-1]}}, in_item.seed};
  assign gtop     = gen_r[VAL_W-1 -: BKT_BITS];
  assign gen_live = (cnt_r < count_r);
  assign hval     = (hwv_r && hwb_r == hb_r) ? hwd_r : hrd_r;

  // histogram memory
  always_comb begin
    h_we = (state_r == S_CLEAR) || hv_r;
    h_wa = (state_r == S_CLEAR) ? clr_r[BKT_BITS-1:0] : hb_r;
    h_wd = (state_r == S_CLEAR) ? '0 : hval + 1'b1;
    h_ra = (state_r == S_HIST) ? gtop
                               : (so_r[BKT_BITS-1:0] ^ (BKT_BITS'(1) << (BKT_BITS-1)));
  end

  always_ff @(posedge clk) begin
    if (h_we) begin
      hist[h_wa] <= h_wd;
    end
    hrd_r <= hist[h_ra];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_item.seed == '0 || in_item.rank == '0 || in_item.rank > in_item.count) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_CLEAR;
          end
        end
      end
      S_CLEAR: if (clr_r == NBKT - 1) state_nxt = S_HIST;
      S_HIST:  if (!gen_live && !hv_r) state_nxt = S_SCAN;
      S_SCAN:  if (found_r) state_nxt = S_STORE;
      S_STORE: begin
        if (!gen_live) state_nxt = (stored_r > DEPTH) ? S_DONE : S_SEL;
      end
      S_SEL:   if (sel_done) state_nxt = S_DONE;
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    busy      = (state_r != S_IDLE);
    out_valid = (state_r == S_DONE);
    out_item  = res_r;
    sel_go    = (state_r == S_STORE) && !gen_live && (stored_r <= DEPTH);
    s_we      = (state_r == S_STORE) && gen_live && (gtop == chosen_r) && (stored_r < DEPTH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      hv_r    <= 1'b0;
      hwv_r   <= 1'b0;
      sv_r    <= 1'b0;
      found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      hv_r    <= (state_r == S_HIST) && gen_live;
      hwv_r   <= (state_r == S_HIST) && hv_r;
      sv_r    <= (state_r == S_SCAN) && (so_r < NBKT);
      if (state_r == S_CLEAR) begin
        found_r <= 1'b0;
      end else if (state_r == S_SCAN && sv_r && !found_r && rem_r < hrd_r) begin
        found_r <= 1'b1;
      end
    end
  end

  // datapath per phase
  always_ff @(posedge clk) begin
    hb_r  <= gtop;
    hwb_r <= hb_r;
    hwd_r <= hval + 1'b1;
    sb_r  <= so_r[BKT_BITS-1:0] ^ (BKT_BITS'(1) << (BKT_BITS-1));
    unique case (state_r)
      S_IDLE: begin
        seed_r  <= seed_x;
        count_r <= in_item.count;
        rem_r   <= in_item.rank - 1'b1;
        clr_r   <= '0;
        res_r.kth_value <= '0;
        res_r.status    <= (in_item.seed == '0) ? ST_OK : ST_RANK_ERR;
      end
      S_CLEAR: begin
        clr_r <= clr_r + 1'b1;
        gen_r <= seed_r;
        cnt_r <= '0;
      end
      S_HIST: begin
        if (gen_live) begin
          gen_r <= xs_next(gen_r);
          cnt_r <= cnt_r + 1'b1;
        end
        so_r <= '0;
      end
      S_SCAN: begin
        so_r <= so_r + 1'b1;
        if (sv_r && !found_r) begin
          if (rem_r < hrd_r) begin
            chosen_r <= sb_r;
          end else begin
            rem_r <= rem_r - hrd_r;
          end
        end
        gen_r    <= seed_r;
        cnt_r    <= '0;
        stored_r <= '0;
      end
      S_STORE: begin
        if (gen_live) begin
          gen_r <= xs_next(gen_r);
          cnt_r <= cnt_r + 1'b1;
          if (gtop == chosen_r) begin
            stored_r <= stored_r + 1'b1;
          end
        end else begin
          res_r.kth_value <= '0;
          res_r.status    <= ST_OVERFLOW;
        end
      end
      S_SEL: begin
        res_r.kth_value <= sel_val;
        res_r.status    <= ST_OK;
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  ksel_select u_select (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (sel_go),
    .n       (stored_r[DCNT_W-1:0]),
    .rem     (rem_r[DADDR_W-1:0]),
    .wr_en   (s_we),
    .wr_addr (stored_r[DADDR_W-1:0]),
    .wr_data (gen_r),
    .done    (sel_done),
    .value   (sel_val)
  );

  // the store pass runs only once a bucket has been chosen
  a_store_found: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_STORE |-> found_r)
    else $error("store pass without a chosen bucket");

  // histogram updates happen only while counting
  a_hist_phase: assert property (@(posedge clk) disable iff (!rst_n)
    hv_r |-> (state_r == S_HIST || state_r == S_SCAN))
    else $error("histogram update outside counting");

  // a result strobe closes the item and frees the block
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy)
    else $error("block still busy after result");

endmodule

// ----- rtl/core/ksel_cell.sv -----
module ksel_cell import ksel_pkg::*; (
  input  logic                clk,
  input  logic                clr,
  input  logic                load,
  input  link_t               cand_in,
  output link_t               cand_out,
  input  link_t               strm_in,
  output link_t               strm_out,
  output logic [DCNT_W-1:0]   lt_cnt,
  output logic [DCNT_W-1:0]   le_cnt
);

  link_t             cand_r, strm_r;
  logic [DCNT_W-1:0] lt_r, le_r;

  // shift candidates during load, pass stream values on every cycle
  always_ff @(posedge clk) begin
    if (load) begin
      cand_r <= cand_in;
    end
    strm_r <= strm_in;
    if (clr) begin
      lt_r <= '0;
      le_r <= '0;
    end else if (strm_in.v) begin
      if ($signed(strm_in.d) < $signed(cand_r.d)) begin
        lt_r <= lt_r + 1'b1;
      end
      if ($signed(strm_in.d) <= $signed(cand_r.d)) begin
        le_r <= le_r + 1'b1;
      end
    end
  end

  assign cand_out = cand_r;
  assign strm_out = strm_r;
  assign lt_cnt   = lt_r;
  assign le_cnt   = le_r;

endmodule

// ----- rtl/core/ksel_select.sv -----
module ksel_select import ksel_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                go,
  input  logic [DCNT_W-1:0]   n,
  input  logic [DADDR_W-1:0]  rem,
  input  logic                wr_en,
  input  logic [DADDR_W-1:0]  wr_addr,
  input  logic [VAL_W-1:0]    wr_data,
  output logic                done,
  output logic [VAL_W-1:0]    value
);

  logic [VAL_W-1:0]   store [DEPTH];
  logic [VAL_W-1:0]   rd_data_r;
  logic [DADDR_W-1:0] rd_addr;
  logic               rd_en;

  sstate_t            state_r, state_nxt;
  logic [DCNT_W-1:0]  base_r;
  logic [DCNT_W:0]    k_r;
  logic               pv_r, pl_r, pc_r;

  link_t              cand [NCELL+1];
  link_t              strm [NCELL+1];
  logic [DCNT_W-1:0]  lt [NCELL];
  logic [DCNT_W-1:0]  le [NCELL];
  logic               hit;
  logic [VAL_W-1:0]   hit_val;
  logic [DCNT_W:0]    ld_idx;

  // bucket store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store[rd_addr];
    end
  end

  assign ld_idx = {1'b0, base_r} + k_r;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = '0;
    if (state_r == SS_LOAD && k_r < NCELL) begin
      rd_en   = 1'b1;
      rd_addr = ld_idx[DADDR_W-1:0];
    end else if (state_r == SS_STREAM && k_r < {1'b0, n}) begin
      rd_en   = 1'b1;
      rd_addr = k_r[DADDR_W-1:0];
    end
  end

  // row of cells
  assign cand[0].v = pc_r;
  assign cand[0].d = rd_data_r;
  assign strm[0].v = pv_r && !pl_r;
  assign strm[0].d = rd_data_r;

  for (genvar i = 0; i < NCELL; i++) begin : g_cell
    ksel_cell u_cell (
      .clk      (clk),
      .clr      (state_r == SS_LOAD),
      .load     (pv_r && pl_r),
      .cand_in  (cand[i]),
      .cand_out (cand[i+1]),
      .strm_in  (strm[i]),
      .strm_out (strm[i+1]),
      .lt_cnt   (lt[i]),
      .le_cnt   (le[i])
    );
  end

  // pick the cell whose candidate sits at the wanted rank
  always_comb begin
    hit     = 1'b0;
    hit_val = '0;
    for (int i = 0; i < NCELL; i++) begin
      if (!hit && cand[i+1].v && lt[i] <= {1'b0, rem} && {1'b0, rem} < le[i]) begin
        hit     = 1'b1;
        hit_val = cand[i+1].d;
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      SS_IDLE:   if (go) state_nxt = SS_LOAD;
      SS_LOAD:   if (k_r == NCELL) state_nxt = SS_STREAM;
      SS_STREAM: if (k_r == {1'b0, n} + NCELL + 1) state_nxt = SS_CHECK;
      SS_CHECK:  state_nxt = hit ? SS_IDLE : SS_LOAD;
      default:   state_nxt = SS_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SS_IDLE;
      pv_r    <= 1'b0;
      pl_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pv_r    <= rd_en;
      pl_r    <= (state_r == SS_LOAD);
    end
  end

  // advance counters
  always_ff @(posedge clk) begin
    pc_r <= (state_r == SS_LOAD) && (ld_idx < {1'b0, n});
    if (state_r != state_nxt) begin
      k_r <= '0;
    end else begin
      k_r <= k_r + 1'b1;
    end
    if (state_r == SS_IDLE) begin
      base_r <= '0;
    end else if (state_r == SS_CHECK) begin
      base_r <= base_r + NCELL[DCNT_W-1:0];
    end
  end

  always_comb begin
    done  = (state_r == SS_CHECK) && hit;
    value = hit_val;
  end

endmodule

// ----- test/xorshift_stream_kth_smallest_chk.sv -----
module xorshift_stream_kth_smallest_chk import ksel_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  input  logic busy,
  input  in_t  in_item,
  input  logic out_valid,
  input  out_t out_item,
  output int   errors,
  output int   pending
);

  out_t kth_q[$];

  // advance the generator one step
  function automatic logic [VAL_W-1:0] xs_step(input logic [VAL_W-1:0] x);
    logic [VAL_W-1:0] y;
    y = x ^ (x << 13);
    y = y ^ (y >> 7);
    y = y ^ (y << 17);
    return y;
  endfunction

  // compute the rank-th smallest value of the generated stream
  function automatic out_t kth_smallest(input in_t it);
    out_t             r;
    logic [VAL_W-1:0] seed64, x;
    int unsigned      hist[NBKT];
    logic [VAL_W-1:0] bucket_vals[$];
    int unsigned      rem, cnt, rnk, n;
    logic [7:0]       pick, b;
    r.kth_value = '0;
    r.status = ST_OK;
    seed64 = {{(VAL_W-SEED_W){it.seed[SEED_W-1]}}, it.seed};
    cnt = it.count;
    rnk = it.rank;
    if (seed64 == '0) return r;
    if (rnk == 0 || rnk > cnt) begin
      r.status = ST_RANK_ERR;
      return r;
    end
    // histogram on the top byte
    foreach (hist[i]) hist[i] = 0;
    x = seed64;
    for (int unsigned i = 0; i < cnt; i++) begin
      hist[x[VAL_W-1 -: 8]]++;
      x = xs_step(x);
    end
    // scan buckets in signed order
    rem = rnk - 1;
    pick = '0;
    for (int o = 0; o < NBKT; o++) begin
      b = 8'(o) ^ 8'h80;
      if (rem < hist[b]) begin
        pick = b;
        break;
      end
      rem -= hist[b];
    end
    // collect the chosen bucket, keyed for unsigned compare
    x = seed64;
    n = 0;
    for (int unsigned i = 0; i < cnt; i++) begin
      if (x[VAL_W-1 -: 8] == pick) begin
        n++;
        if (n <= DEPTH) bucket_vals.push_back(x ^ 64'h8000_0000_0000_0000);
      end
      x = xs_step(x);
    end
    if (n > DEPTH) begin
      r.status = ST_OVERFLOW;
      return r;
    end
    bucket_vals.sort();
    if (rem < n) r.kth_value = bucket_vals[rem] ^ 64'h8000_0000_0000_0000;
    return r;
  endfunction

  assign pending = kth_q.size();

  // record expectations on accepted items, compare results
  always @(posedge clk) begin
    out_t want;
    int   nerr;
    nerr = 0;
    if (!rst_n) begin
      errors <= 0;
    end else begin
      if (start && !busy) kth_q.push_back(kth_smallest(in_item));
      if (out_valid) begin
        if (kth_q.size() == 0) begin
          $error("result with no item outstanding");
          nerr++;
        end else begin
          want = kth_q.pop_front();
          if (out_item.kth_value !== want.kth_value) begin
            $error("kth_value: expected %0d, got %0d", want.kth_value, out_item.kth_value);
            nerr++;
          end
          if (out_item.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_item.status);
            nerr++;
          end
        end
      end
      errors <= errors + nerr;
    end
  end

endmodule

// ----- test/xorshift_stream_kth_smallest_tb.sv -----
module xorshift_stream_kth_smallest_tb import ksel_pkg::*;;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_item;
  logic out_valid;
  out_t out_item;
  int   errors;
  int   pending;
  int   cycles;

  xorshift_stream_kth_smallest DUT (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item)
  );

  xorshift_stream_kth_smallest_chk u_chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_item(in_item), .out_valid(out_valid), .out_item(out_item),
    .errors(errors), .pending(pending)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // stop a hung run
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > 20000000) begin
        $display("xorshift_stream_kth_smallest_tb: done, errors");
        $finish;
      end
    end
  end

  // hold the item until the block takes it
  task automatic send(input logic signed [31:0] sd, input int unsigned cnt,
                      input int unsigned rk);
    int gap;
    gap = $urandom_range(0, 8);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      start = 0;
      repeat (gap) @(negedge clk);
    end
    in_item.seed = sd;
    in_item.count = cnt[CNT_W-1:0];
    in_item.rank = rk[CNT_W-1:0];
    start = 1;
    do @(posedge clk); while (busy);
    @(negedge clk);
  endtask

  initial begin
    int unsigned cnt;
    logic signed [31:0] sd;
    start = 0;
    in_item = '0;
    rst_n = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // directed: extremes and special cases
    send(32'sd0, 24'hFFFFFF, 5);
    send(32'sd1, 1, 1);
    send(-32'sd1, 1, 1);
    send(32'h7FFFFFFF, 100, 100);
    send(32'h80000000, 100, 1);
    send(32'sd12345, 0, 1);
    send(32'sd12345, 50, 0);
    send(32'sd12345, 50, 51);
    send(32'sd777, 24'hFFFFFF, 0);
    send(32'sd777, 10, 24'hFFFFFF);
    send(32'sd3, 200, 100);
    send(-32'sd99, 300, 1);
    send(-32'sd99, 300, 300);
    send(32'h5555AAAA, 5000, 2500);
    send(32'hAAAA5555, 8000, 7999);
    send(32'sd42, 1200000, 600000);

    // random: mostly valid requests with small counts
    for (int i = 0; i < 100; i++) begin
      sd = $urandom;
      cnt = $urandom_range(1, 400);
      if ($urandom_range(0, 19) == 0) cnt = $urandom_range(1000, 20000);
      case ($urandom_range(0, 9))
        0: send(32'sd0, cnt, $urandom_range(1, cnt));
        1: send(sd, cnt, $urandom_range(cnt + 1, 24'hFFFFFF));
        default: send(sd == 0 ? 32'sd1 : sd, cnt, $urandom_range(1, cnt));
      endcase
    end
    start = 0;

    // drain outstanding results
    while (pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) begin
      $display("xorshift_stream_kth_smallest_tb: done, clean");
    end else begin
      $display("xorshift_stream_kth_smallest_tb: done, errors");
    end
    $finish;
  end

endmodule
